// ----- design/tccc_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cursor control package
// Shared types and constants for the cursor controller and its step logic.
// ----------------------------------------------------------------------------
package tccc_pkg;

   // Ceilings on the character grid. The cursor registers cannot hold more.
   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 128;

   localparam int CELL_SHIFT_X = 3;  // 8 pixels per cell column
   localparam int CELL_SHIFT_Y = 4;  // 16 pixels per cell row
   localparam int TAB_STOP     = 8;

   localparam logic [8:0]  COLUMNS_RESET = 9'd100;
   localparam logic [7:0]  ROWS_RESET    = 8'd37;
   localparam logic [23:0] FG_RESET      = 24'h00FF00;
   localparam logic [23:0] BG_RESET      = 24'h000000;

   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_RETURN    = 8'd13;
   localparam logic [7:0] CHAR_SPACE     = 8'd32;

   typedef enum logic [1:0] {
      MODE_PUT    = 2'd0,
      MODE_CURSOR = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DRAW   = 2'd0,
      KIND_SCROLL = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_ENABLE  = 3'd0,
      REG_COLUMNS = 3'd1,
      REG_ROWS    = 3'd2,
      REG_FG      = 3'd3,
      REG_BG      = 3'd4
   } reg_index_type;

   // First command of an item, plus a flag for a trailing scroll.
   typedef struct packed {
      kind_type    kind;
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
      logic [6:0]  glyph;
      logic        scroll_follows;
      logic [6:0]  row;
      logic [7:0]  col;
   } step_type;

endpackage

// ----- design/tccc_cursor_step.sv -----
// ----------------------------------------------------------------------------
// Cursor step
// Works out the commands and the new cursor position for one console beat.
// ----------------------------------------------------------------------------
module tccc_cursor_step (
   input  logic                    enable,
   input  logic [8:0]              text_columns,
   input  logic [7:0]              text_rows,
   input  logic [6:0]              cur_row,
   input  logic [7:0]              cur_col,
   input  logic [1:0]              mode,
   input  logic [7:0]              char_code,
   input  logic signed [8:0]       row_request,
   input  logic signed [9:0]       col_request,
   output tccc_pkg::step_type      step
);
   import tccc_pkg::*;

   localparam logic [8:0] COL_LIMIT = 9'((MAX_COLUMNS < 256) ? MAX_COLUMNS : 256);
   localparam logic [7:0] ROW_LIMIT = 8'((MAX_ROWS < 128) ? MAX_ROWS : 128);

   logic [8:0] cols;
   logic [7:0] rows;
   logic [8:0] col_n;
   logic [7:0] row_n;
   logic [8:0] col_w;
   logic [7:0] row_w;
   logic [7:0] draw_col;
   logic       draw;
   logic       scroll;
   logic [6:0] draw_glyph;
   logic [6:0] row_fin;
   logic [7:0] col_fin;
   logic [8:0] tab_sum;

   always_comb begin
      cols = text_columns;
      if (cols == 9'd0) cols = 9'd1;
      if (cols > COL_LIMIT) cols = COL_LIMIT;
      rows = text_rows;
      if (rows == 8'd0) rows = 8'd1;
      if (rows > ROW_LIMIT) rows = ROW_LIMIT;
   end

   // Character handling, then the wrap and scroll checks.
   always_comb begin
      col_n      = {1'b0, cur_col};
      row_n      = {1'b0, cur_row};
      draw       = 1'b0;
      draw_col   = cur_col;
      draw_glyph = char_code[6:0];
      tab_sum    = {1'b0, cur_col} + 9'(TAB_STOP);
      case (char_code)
         CHAR_NEWLINE: begin
            col_n = 9'd0;
            row_n = row_n + 8'd1;
         end
         CHAR_RETURN: begin
            col_n = 9'd0;
         end
         CHAR_TAB: begin
            col_n = tab_sum & ~9'(TAB_STOP - 1);
         end
         CHAR_BACKSPACE: begin
            if (cur_col != 8'd0) begin
               col_n      = col_n - 9'd1;
               draw       = 1'b1;
               draw_col   = cur_col - 8'd1;
               draw_glyph = CHAR_SPACE[6:0];
            end
         end
         default: begin
            if (char_code inside {[8'd32:8'd127]}) begin
               draw  = 1'b1;
               col_n = col_n + 9'd1;
            end
         end
      endcase
      col_w = col_n;
      row_w = row_n;
      if (col_n >= cols) begin
         col_w = 9'd0;
         row_w = row_n + 8'd1;
      end
      scroll  = (row_w >= rows);
      row_fin = scroll ? 7'(rows - 8'd1) : row_w[6:0];
      col_fin = col_w[7:0];
   end

   always_comb begin
      step      = '0;
      step.kind = KIND_NONE;
      step.row  = cur_row;
      step.col  = cur_col;
      case (mode)
         MODE_PUT: begin
            if (enable) begin
               step.row = row_fin;
               step.col = col_fin;
               if (draw) begin
                  step.kind           = KIND_DRAW;
                  step.pixel_x        = {draw_col, 3'b000};
                  step.pixel_y        = {cur_row, 4'b0000};
                  step.glyph          = draw_glyph;
                  step.scroll_follows = scroll;
               end else if (scroll) begin
                  step.kind = KIND_SCROLL;
               end
            end
         end
         MODE_CURSOR: begin
            if (row_request[8]) begin
               step.row = 7'd0;
            end else if (row_request[7:0] >= rows) begin
               step.row = 7'(rows - 8'd1);
            end else begin
               step.row = row_request[6:0];
            end
            if (col_request[9]) begin
               step.col = 8'd0;
            end else if (col_request[8:0] >= cols) begin
               step.col = 8'(cols - 9'd1);
            end else begin
               step.col = col_request[7:0];
            end
         end
         MODE_CLEAR: begin
            if (enable) begin
               step.kind = KIND_CLEAR;
               step.row  = 7'd0;
               step.col  = 8'd0;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- design/text_console_cursor_control.sv -----
// A result beat is registered and presented in the cycle after its request beat is taken.
// Throughput: one request beat per cycle while the output does not stall; an
// item that draws and then scrolls holds the result register for two beats,
// so the next request stalls until the scroll beat is taken. The single result
// register plus the scroll-pending flag set this figure. Reset (synchronous):
// cursor at row 0, column 0; console disabled, 100 x 37 grid, green on black.
// ----------------------------------------------------------------------------
// Text console cursor control
// Tracks the console cursor and issues draw, scroll and clear commands.
// ----------------------------------------------------------------------------
module text_console_cursor_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [7:0]          req_char_code,
   input  logic signed [8:0]   req_row_request,
   input  logic signed [9:0]   req_col_request,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_command_kind,
   output logic [10:0]         rsp_pixel_x,
   output logic [10:0]         rsp_pixel_y,
   output logic [6:0]          rsp_glyph_code,
   output logic [23:0]         rsp_draw_foreground,
   output logic [23:0]         rsp_draw_background,
   output logic [6:0]          rsp_cursor_row_now,
   output logic [7:0]          rsp_cursor_col_now,
   output logic                rsp_last_result
);
   import tccc_pkg::*;

   logic        enable_ff;
   logic [8:0]  columns_ff;
   logic [7:0]  rows_ff;
   logic [23:0] fg_ff;
   logic [23:0] bg_ff;
   logic [6:0]  cursor_row_ff;
   logic [7:0]  cursor_col_ff;

   logic        valid_ff;
   logic        pend_ff;
   kind_type    kind_ff;
   logic [10:0] x_ff;
   logic [10:0] y_ff;
   logic [6:0]  glyph_ff;
   logic        last_ff;
   logic [6:0]  row_out_ff;
   logic [7:0]  col_out_ff;

   step_type    step;
   logic        req_take;
   logic        rsp_take;

   // Users must write configuration only with no beat in flight; not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
         fg_ff      <= FG_RESET;
         bg_ff      <= BG_RESET;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_ENABLE:  enable_ff  <= csr_write_data[0];
            REG_COLUMNS: columns_ff <= csr_write_data[8:0];
            REG_ROWS:    rows_ff    <= csr_write_data[7:0];
            REG_FG:      fg_ff      <= csr_write_data;
            REG_BG:      bg_ff      <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   tccc_cursor_step u_step (
      .enable       (enable_ff),
      .text_columns (columns_ff),
      .text_rows    (rows_ff),
      .cur_row      (cursor_row_ff),
      .cur_col      (cursor_col_ff),
      .mode         (req_mode),
      .char_code    (req_char_code),
      .row_request  (req_row_request),
      .col_request  (req_col_request),
      .step         (step)
   );

   assign rsp_take  = valid_ff && !rsp_stall;
   assign req_stall = valid_ff && (rsp_stall || pend_ff);
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_row_ff <= 7'd0;
         cursor_col_ff <= 8'd0;
         valid_ff      <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         if (rsp_take && pend_ff) begin
            pend_ff <= 1'b0;
         end else if (req_take) begin
            cursor_row_ff <= step.row;
            cursor_col_ff <= step.col;
            valid_ff      <= 1'b1;
            pend_ff       <= step.scroll_follows;
         end else if (rsp_take) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // The trailing scroll beat reuses the cursor fields of the draw beat.
   always_ff @(posedge clock) begin
      if (rsp_take && pend_ff) begin
         kind_ff  <= KIND_SCROLL;
         x_ff     <= 11'd0;
         y_ff     <= 11'd0;
         glyph_ff <= 7'd0;
         last_ff  <= 1'b1;
      end else if (req_take) begin
         kind_ff    <= step.kind;
         x_ff       <= step.pixel_x;
         y_ff       <= step.pixel_y;
         glyph_ff   <= step.glyph;
         last_ff    <= !step.scroll_follows;
         row_out_ff <= step.row;
         col_out_ff <= step.col;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_command_kind    = kind_ff;
   assign rsp_pixel_x         = x_ff;
   assign rsp_pixel_y         = y_ff;
   assign rsp_glyph_code      = glyph_ff;
   assign rsp_draw_foreground = fg_ff;
   assign rsp_draw_background = bg_ff;
   assign rsp_cursor_row_now  = row_out_ff;
   assign rsp_cursor_col_now  = col_out_ff;
   assign rsp_last_result     = last_ff;

endmodule
